>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the mesh index generator modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CMIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CMIG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cmig_pkg.sv
// ---------------------------------------------------------------------------
// cmig_pkg
// Types and constants of the cylinder / cone mesh index generator
// ---------------------------------------------------------------------------
`default_nettype none

package cmig_pkg;

  // default slice limit
  localparam int MAX_SLICES_DEF = 1024;

  // field widths
  localparam int TNUM_W      = 12;
  localparam int IDX_W       = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int MODE_W      = 2;

  // reset value of the slice count
  localparam int SLICES_RESET = 16;

  // shape modes
  typedef enum logic [MODE_W-1:0] {
    SHAPE_CONE    = 2'd0,
    SHAPE_CYL     = 2'd1,
    SHAPE_LINE    = 2'd2,
    SHAPE_INVALID = 2'd3
  } shape_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAPE_MODE = 1'd0,
    CFG_NUM_SLICES = 1'd1
  } cfg_reg_t;

  // part of the mesh a triangle belongs to
  typedef enum logic [2:0] {
    RGN_NONE   = 3'd0,
    RGN_LINE   = 3'd1,
    RGN_APEX   = 3'd2,
    RGN_BASE   = 3'd3,
    RGN_SIDE   = 3'd4,
    RGN_BOTTOM = 3'd5
  } region_t;

  // control that travels with an item down the pipe
  typedef struct packed {
    region_t region;
    logic    odd;
    logic    last;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/cmig_cfg.sv
// ---------------------------------------------------------------------------
// cmig_cfg
// Configuration registers, slice count saturation and derived ring bounds
// ---------------------------------------------------------------------------
`default_nettype none

module cmig_cfg #(
  parameter int MAX_SLICES = cmig_pkg::MAX_SLICES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [cmig_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [cmig_pkg::CFG_DATA_W-1:0]     cfg_data,
  output cmig_pkg::shape_t                   mode,
  output logic [$clog2(MAX_SLICES+1)-1:0]    n,
  output logic [$clog2(MAX_SLICES+1)-1:0]    n_m1,
  output logic [$clog2(MAX_SLICES+1)+1:0]    n_p1,
  output logic [$clog2(MAX_SLICES+1):0]      n_x2,
  output logic [$clog2(MAX_SLICES+1)+1:0]    n_x3,
  output logic [$clog2(MAX_SLICES+1)+1:0]    n_x4,
  output logic [$clog2(MAX_SLICES+1)+1:0]    n_x2p1
);

  localparam int NW     = $clog2(MAX_SLICES + 1);
  localparam int TW     = NW + 2;
  localparam int CW     = (TW > 13) ? TW : 13;
  localparam int RST_SL = (cmig_pkg::SLICES_RESET > MAX_SLICES) ? MAX_SLICES
                                                               : cmig_pkg::SLICES_RESET;

  cmig_pkg::shape_t   mode_r, mode_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [NW-1:0]      n_m1_r, n_m1_nxt;
  logic [TW-1:0]      n_p1_r, n_p1_nxt;
  logic [NW:0]        n_x2_r, n_x2_nxt;
  logic [TW-1:0]      n_x3_r, n_x3_nxt;
  logic [TW-1:0]      n_x4_r, n_x4_nxt;
  logic [TW-1:0]      n_x2p1_r, n_x2p1_nxt;
  logic [CW-1:0]      data_w;
  logic [CW-1:0]      sat_w;

  assign cfg_ready = 1'b1;

  // clamp the slice count and work out the derived bounds
  always_comb begin
    data_w     = CW'(cfg_data);
    sat_w      = (data_w > CW'(MAX_SLICES)) ? CW'(MAX_SLICES) : data_w;
    mode_nxt   = mode_r;
    n_nxt      = n_r;
    n_m1_nxt   = n_m1_r;
    n_p1_nxt   = n_p1_r;
    n_x2_nxt   = n_x2_r;
    n_x3_nxt   = n_x3_r;
    n_x4_nxt   = n_x4_r;
    n_x2p1_nxt = n_x2p1_r;
    if (cfg_valid) begin
      case (cfg_index)
        cmig_pkg::CFG_SHAPE_MODE: begin
          mode_nxt = cmig_pkg::shape_t'(cfg_data[cmig_pkg::MODE_W-1:0]);
        end
        cmig_pkg::CFG_NUM_SLICES: begin
          n_nxt      = NW'(sat_w);
          n_m1_nxt   = NW'(sat_w - CW'(1));
          n_p1_nxt   = TW'(sat_w + CW'(1));
          n_x2_nxt   = (NW+1)'(sat_w << 1);
          n_x3_nxt   = TW'((sat_w << 1) + sat_w);
          n_x4_nxt   = TW'(sat_w << 2);
          n_x2p1_nxt = TW'((sat_w << 1) + CW'(1));
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= cmig_pkg::SHAPE_CYL;
      n_r      <= NW'(RST_SL);
      n_m1_r   <= NW'(RST_SL - 1);
      n_p1_r   <= TW'(RST_SL + 1);
      n_x2_r   <= (NW+1)'(2 * RST_SL);
      n_x3_r   <= TW'(3 * RST_SL);
      n_x4_r   <= TW'(4 * RST_SL);
      n_x2p1_r <= TW'(2 * RST_SL + 1);
    end else begin
      mode_r   <= mode_nxt;
      n_r      <= n_nxt;
      n_m1_r   <= n_m1_nxt;
      n_p1_r   <= n_p1_nxt;
      n_x2_r   <= n_x2_nxt;
      n_x3_r   <= n_x3_nxt;
      n_x4_r   <= n_x4_nxt;
      n_x2p1_r <= n_x2p1_nxt;
    end
  end

  assign mode   = mode_r;
  assign n      = n_r;
  assign n_m1   = n_m1_r;
  assign n_p1   = n_p1_r;
  assign n_x2   = n_x2_r;
  assign n_x3   = n_x3_r;
  assign n_x4   = n_x4_r;
  assign n_x2p1 = n_x2p1_r;

endmodule

`default_nettype wire

>>> rtl/cmig_locate.sv
// ---------------------------------------------------------------------------
// cmig_locate
// Stages 1 and 2: find the mesh part of a triangle and its ring position
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cmig_locate #(
  parameter int MAX_SLICES = cmig_pkg::MAX_SLICES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input item
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [cmig_pkg::TNUM_W-1:0]          tnum,
  // configuration
  input  cmig_pkg::shape_t                    mode,
  input  wire [$clog2(MAX_SLICES+1)-1:0]      n,
  input  wire [$clog2(MAX_SLICES+1):0]        n_x2,
  input  wire [$clog2(MAX_SLICES+1)+1:0]      n_x3,
  input  wire [$clog2(MAX_SLICES+1)+1:0]      n_x4,
  // to the index stages
  output logic                                loc_valid,
  input  wire                                 loc_ready,
  output logic [$clog2(MAX_SLICES+1)-1:0]     loc_pos,
  output cmig_pkg::ctl_t                      loc_ctl
);

  localparam int NW = $clog2(MAX_SLICES + 1);
  localparam int TW = NW + 2;
  localparam int CW = (TW > 13) ? TW : 13;

  logic                       rdy1, rdy2;
  logic                       v1_r, v2_r;
  logic [cmig_pkg::TNUM_W-1:0] t1_r;
  cmig_pkg::region_t          rgn1_r, rgn_nxt;
  logic                       last1_r, last_nxt;
  logic [NW-1:0]              pos2_r, pos_nxt;
  cmig_pkg::ctl_t             ctl2_r, ctl_nxt;
  logic [CW-1:0]              tw, total, off, sub;

  // bubble-collapsing handshake
  assign rdy2      = !v2_r || loc_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // stage 1: range compares against the region bounds
  always_comb begin
    tw      = CW'(tnum);
    rgn_nxt = cmig_pkg::RGN_NONE;
    total   = '0;
    case (mode)
      cmig_pkg::SHAPE_CONE: begin
        total = CW'(n_x2);
        if (tw < CW'(n))          rgn_nxt = cmig_pkg::RGN_APEX;
        else if (tw < CW'(n_x2))  rgn_nxt = cmig_pkg::RGN_BASE;
      end
      cmig_pkg::SHAPE_CYL: begin
        total = CW'(n_x4);
        if (tw < CW'(n))          rgn_nxt = cmig_pkg::RGN_APEX;
        else if (tw < CW'(n_x3))  rgn_nxt = cmig_pkg::RGN_SIDE;
        else if (tw < CW'(n_x4))  rgn_nxt = cmig_pkg::RGN_BOTTOM;
      end
      cmig_pkg::SHAPE_LINE: begin
        total = CW'(1);
        if (tw == '0)             rgn_nxt = cmig_pkg::RGN_LINE;
      end
      default: begin
        total = '0;
      end
    endcase
    last_nxt = (rgn_nxt != cmig_pkg::RGN_NONE) && ((tw + CW'(1)) == total);
  end

  // stage 2: offset into the ring, side triangles come in pairs
  always_comb begin
    case (rgn1_r)
      cmig_pkg::RGN_BASE:   off = CW'(n);
      cmig_pkg::RGN_SIDE:   off = CW'(n);
      cmig_pkg::RGN_BOTTOM: off = CW'(n_x3);
      default:              off = '0;
    endcase
    sub = CW'(t1_r) - off;
    if (rgn1_r == cmig_pkg::RGN_SIDE) pos_nxt = sub[NW:1];
    else                              pos_nxt = sub[NW-1:0];
    ctl_nxt.region = rgn1_r;
    ctl_nxt.odd    = (rgn1_r == cmig_pkg::RGN_SIDE) && sub[0];
    ctl_nxt.last   = last1_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && rdy1) begin
      t1_r    <= tnum;
      rgn1_r  <= rgn_nxt;
      last1_r <= last_nxt;
    end
    if (v1_r && rdy2) begin
      pos2_r <= pos_nxt;
      ctl2_r <= ctl_nxt;
    end
  end

  assign loc_valid = v2_r;
  assign loc_pos   = pos2_r;
  assign loc_ctl   = ctl2_r;

  `CMIG_ASSERT(a_pos_on_ring, v2_r && (ctl2_r.region == cmig_pkg::RGN_APEX || ctl2_r.region == cmig_pkg::RGN_BASE || ctl2_r.region == cmig_pkg::RGN_SIDE || ctl2_r.region == cmig_pkg::RGN_BOTTOM) |-> pos2_r < n, "ring position beyond slice count")
  `CMIG_ASSERT(a_odd_side_only, v2_r && ctl2_r.odd |-> ctl2_r.region == cmig_pkg::RGN_SIDE, "odd flag outside side region")

endmodule

`default_nettype wire

>>> rtl/cmig_index.sv
// ---------------------------------------------------------------------------
// cmig_index
// Stages 3 and 4: ring neighbor sums and vertex index selection
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cmig_index #(
  parameter int MAX_SLICES = cmig_pkg::MAX_SLICES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // from the locate stages
  input  wire                                  loc_valid,
  output logic                                 loc_ready,
  input  wire [$clog2(MAX_SLICES+1)-1:0]       loc_pos,
  input  cmig_pkg::ctl_t                       loc_ctl,
  // configuration
  input  wire [$clog2(MAX_SLICES+1)-1:0]       n_m1,
  input  wire [$clog2(MAX_SLICES+1)+1:0]       n_p1,
  input  wire [$clog2(MAX_SLICES+1)+1:0]       n_x2p1,
  // result item
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [cmig_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tuser,
  output logic                                 out_tlast
);

  localparam int NW = $clog2(MAX_SLICES + 1);
  localparam int IW = NW + 2;

  logic                        rdy3, rdy4;
  logic                        v3_r, v4_r;
  cmig_pkg::ctl_t              ctl3_r;
  logic [IW-1:0]               p1_r, p2_r, q1_r, q2_r;
  logic [IW-1:0]               p1_nxt, p2_nxt, q1_nxt, q2_nxt;
  logic [IW-1:0]               posw;
  logic                        wrap;
  logic [IW-1:0]               a_w, b_w, c_w;
  logic [cmig_pkg::IDX_W-1:0]  a4_r, b4_r, c4_r;
  logic                        ok4_r, last4_r;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign loc_ready = rdy3;

  // stage 3: ring vertex and its neighbor, on both rings
  always_comb begin
    posw   = IW'(loc_pos);
    wrap   = (loc_pos == n_m1);
    p1_nxt = posw + IW'(1);
    p2_nxt = wrap ? IW'(1) : posw + IW'(2);
    q1_nxt = posw + n_p1;
    q2_nxt = wrap ? n_p1 : posw + n_p1 + IW'(1);
  end

  // stage 4: pick the three corners for the mesh part
  always_comb begin
    a_w = '0;
    b_w = '0;
    c_w = '0;
    case (ctl3_r.region)
      cmig_pkg::RGN_APEX: begin
        b_w = p1_r;
        c_w = p2_r;
      end
      cmig_pkg::RGN_BASE: begin
        a_w = n_p1;
        b_w = p2_r;
        c_w = p1_r;
      end
      cmig_pkg::RGN_SIDE: begin
        b_w = q1_r;
        if (ctl3_r.odd) begin
          a_w = p2_r;
          c_w = q2_r;
        end else begin
          a_w = p1_r;
          c_w = p2_r;
        end
      end
      cmig_pkg::RGN_BOTTOM: begin
        a_w = n_x2p1;
        b_w = q2_r;
        c_w = q1_r;
      end
      cmig_pkg::RGN_LINE: begin
        b_w = IW'(1);
      end
      default: begin
        a_w = '0;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= loc_valid;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (loc_valid && rdy3) begin
      ctl3_r <= loc_ctl;
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      q1_r   <= q1_nxt;
      q2_r   <= q2_nxt;
    end
    if (v3_r && rdy4) begin
      a4_r    <= cmig_pkg::IDX_W'(a_w);
      b4_r    <= cmig_pkg::IDX_W'(b_w);
      c4_r    <= cmig_pkg::IDX_W'(c_w);
      ok4_r   <= (ctl3_r.region != cmig_pkg::RGN_NONE);
      last4_r <= ctl3_r.last;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {4'b0000, c4_r, b4_r, a4_r};
  assign out_tuser  = ok4_r;
  assign out_tlast  = last4_r;

  `CMIG_ASSERT(a_final_in_range, out_tvalid && out_tlast |-> out_tuser, "final triangle flagged out of range")
  `CMIG_ASSERT(a_miss_zero, out_tvalid && !out_tuser |-> out_tdata == '0, "out of range item carries indices")
  `CMIG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

`default_nettype wire

>>> rtl/cylinder_mesh_index_generator.sv
// ---------------------------------------------------------------------------
// cylinder_mesh_index_generator
// Vertex indices of one triangle of a tessellated cone or capped cylinder
// ---------------------------------------------------------------------------
// Usage:
//   cfg_*  : write shape_mode (index 0) or num_slices (index 1) while the
//            pipe is empty; always ready, the value takes effect next cycle.
//            num_slices above MAX_SLICES is clamped to MAX_SLICES.
//   in_*   : one triangle number per item in in_tdata[11:0].
//   out_*  : one result item per input item, in order; tdata holds the
//            three vertex indices, tuser says the triangle exists, tlast
//            marks the last triangle of the mesh.
// Pipeline: four register stages, two in cmig_locate and two in cmig_index;
//   an accepted item moves through them in order.
// Throughput: one item per cycle, sustained while out_tready stays high.
// Stall: each stage holds its item while the one below is full and stalled; in_tready
//   drops only once every stage is full, so nothing is lost or repeated.
// Reset: all stages empty, shape_mode = capped cylinder, num_slices = 16.
// ---------------------------------------------------------------------------
`default_nettype none

module cylinder_mesh_index_generator #(
  parameter int MAX_SLICES = cmig_pkg::MAX_SLICES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [cmig_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [cmig_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [cmig_pkg::IN_TDATA_W-1:0]      in_tdata,   // [11:0] triangle_number
  // result stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [cmig_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [11:0] first_index,
                                                          // [23:12] second_index,
                                                          // [35:24] third_index
  output logic                                out_tuser,  // [0] in_range
  output logic                                out_tlast   // is_final
);

  localparam int NW = $clog2(MAX_SLICES + 1);

  cmig_pkg::shape_t  mode;
  logic [NW-1:0]     n, n_m1;
  logic [NW+1:0]     n_p1, n_x3, n_x4, n_x2p1;
  logic [NW:0]       n_x2;
  logic              loc_valid, loc_ready;
  logic [NW-1:0]     loc_pos;
  cmig_pkg::ctl_t    loc_ctl;

  // configuration registers
  cmig_cfg #(.MAX_SLICES(MAX_SLICES)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .n         (n),
    .n_m1      (n_m1),
    .n_p1      (n_p1),
    .n_x2      (n_x2),
    .n_x3      (n_x3),
    .n_x4      (n_x4),
    .n_x2p1    (n_x2p1)
  );

  // region and ring position
  cmig_locate #(.MAX_SLICES(MAX_SLICES)) u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .tnum      (in_tdata[cmig_pkg::TNUM_W-1:0]),
    .mode      (mode),
    .n         (n),
    .n_x2      (n_x2),
    .n_x3      (n_x3),
    .n_x4      (n_x4),
    .loc_valid (loc_valid),
    .loc_ready (loc_ready),
    .loc_pos   (loc_pos),
    .loc_ctl   (loc_ctl)
  );

  // vertex indices and output register
  cmig_index #(.MAX_SLICES(MAX_SLICES)) u_index (
    .clk        (clk),
    .rst_n      (rst_n),
    .loc_valid  (loc_valid),
    .loc_ready  (loc_ready),
    .loc_pos    (loc_pos),
    .loc_ctl    (loc_ctl),
    .n_m1       (n_m1),
    .n_p1       (n_p1),
    .n_x2p1     (n_x2p1),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the cylinder / cone mesh index generator
// ---------------------------------------------------------------------------
// Triangle numbers are streamed into the block under several shape modes and
// slice counts. Each accepted item is turned into its expected vertex indices
// by a local predictor. Every result item is compared field by field against
// the oldest pending prediction. Directed cases cover every mesh region, the
// wrap on the last slice, the last triangle, out-of-range numbers, zero and
// clamped slice counts. Random segments follow, with idling on both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH  = 4;        // register stages, from the block's header
  localparam int CYCLE_LIMIT = 200_000;  // far above the slowest correct run
  localparam int SEG_ITEMS   = 40;
  localparam int SEGS_PER_PH = 8;
  localparam int EXP_DEPTH   = 16;       // well above the items the pipe can hold

  // one result item, as the block should produce it
  typedef struct {
    logic [cmig_pkg::IDX_W-1:0] first_idx;
    logic [cmig_pkg::IDX_W-1:0] second_idx;
    logic [cmig_pkg::IDX_W-1:0] third_idx;
    logic                       in_range;
    logic                       is_final;
  } tri_result_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [cmig_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [cmig_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [cmig_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [cmig_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             out_tlast;

  // local copy of the configuration, reset values
  cmig_pkg::shape_t                cur_shape  = cmig_pkg::SHAPE_CYL;
  logic [cmig_pkg::CFG_DATA_W-1:0] cur_slices =
    cmig_pkg::CFG_DATA_W'(cmig_pkg::SLICES_RESET);

  // predictions waiting for their result, oldest at the read count
  tri_result_t expect_ring[EXP_DEPTH];
  int unsigned exp_wr         = 0;
  int unsigned exp_rd         = 0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  cylinder_mesh_index_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pending_count();
    return exp_wr - exp_rd;
  endfunction

  // next vertex on a ring that starts at base, wrapping back to base
  function automatic int unsigned ring_step(int unsigned base, int unsigned pos,
                                            int unsigned n);
    return (pos + 1 < n) ? base + pos + 1 : base;
  endfunction

  function automatic int unsigned clamp_slices(logic [cmig_pkg::CFG_DATA_W-1:0] slices);
    return (slices > cmig_pkg::MAX_SLICES_DEF) ? cmig_pkg::MAX_SLICES_DEF : int'(slices);
  endfunction

  // number of triangles in the mesh
  function automatic int unsigned mesh_size(cmig_pkg::shape_t shape,
                                            logic [cmig_pkg::CFG_DATA_W-1:0] slices);
    int unsigned n;
    n = clamp_slices(slices);
    case (shape)
      cmig_pkg::SHAPE_CONE: return 2 * n;
      cmig_pkg::SHAPE_CYL:  return 4 * n;
      cmig_pkg::SHAPE_LINE: return 1;
      default:              return 0;
    endcase
  endfunction

  // vertex indices of one triangle of the current mesh
  function automatic tri_result_t mesh_triangle(cmig_pkg::shape_t shape,
                                                logic [cmig_pkg::CFG_DATA_W-1:0] slices,
                                                logic [cmig_pkg::TNUM_W-1:0] tnum);
    int unsigned n, t, total, s, pos, a, b, c, k, j;
    bit          ok;
    tri_result_t r;
    n = clamp_slices(slices);
    t = tnum;
    total = mesh_size(shape, slices);
    a = 0; b = 0; c = 0; ok = 0;
    case (shape)
      cmig_pkg::SHAPE_CONE: begin
        if (t < n) begin
          a = 0; b = t + 1; c = ring_step(1, t, n); ok = 1;
        end else if (t < total) begin
          s = t - n;
          a = n + 1; b = ring_step(1, s, n); c = s + 1; ok = 1;
        end
      end
      cmig_pkg::SHAPE_CYL: begin
        if (t < n) begin
          a = 0; b = t + 1; c = ring_step(1, t, n); ok = 1;
        end else if (t < 3 * n) begin
          // two side triangles per slice
          s   = t - n;
          pos = s >> 1;
          k   = ring_step(1, pos, n);
          j   = ring_step(n + 1, pos, n);
          if (s[0] == 1'b0) begin
            a = pos + 1; b = pos + 1 + n; c = k;
          end else begin
            a = k; b = pos + 1 + n; c = j;
          end
          ok = 1;
        end else if (t < total) begin
          pos = t - 3 * n;
          a = 2 * n + 1; b = ring_step(n + 1, pos, n); c = n + 1 + pos; ok = 1;
        end
      end
      cmig_pkg::SHAPE_LINE: begin
        if (t == 0) begin
          a = 0; b = 1; c = 0; ok = 1;
        end
      end
      default: ;
    endcase
    if (!ok) begin
      a = 0; b = 0; c = 0;
    end
    r.first_idx  = a[cmig_pkg::IDX_W-1:0];
    r.second_idx = b[cmig_pkg::IDX_W-1:0];
    r.third_idx  = c[cmig_pkg::IDX_W-1:0];
    r.in_range   = ok;
    r.is_final   = ok && (t + 1 == total);
    return r;
  endfunction

  // record accepted items, check results, track register writes
  always @(posedge clk) begin
    tri_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expect_ring[exp_wr % EXP_DEPTH] =
          mesh_triangle(cur_shape, cur_slices, in_tdata[cmig_pkg::TNUM_W-1:0]);
        exp_wr++;
      end
      if (out_tvalid && out_tready) begin
        if (pending_count() == 0) begin
          $error("unexpected result item: tdata %h", out_tdata);
          mismatch_count++;
        end else begin
          want = expect_ring[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_tdata[11:0] !== want.first_idx) begin
            $error("first_index: expected %0d, got %0d", want.first_idx, out_tdata[11:0]);
            mismatch_count++;
          end
          if (out_tdata[23:12] !== want.second_idx) begin
            $error("second_index: expected %0d, got %0d", want.second_idx,
                   out_tdata[23:12]);
            mismatch_count++;
          end
          if (out_tdata[35:24] !== want.third_idx) begin
            $error("third_index: expected %0d, got %0d", want.third_idx, out_tdata[35:24]);
            mismatch_count++;
          end
          if (out_tuser !== want.in_range) begin
            $error("in_range: expected %0d, got %0d", want.in_range, out_tuser);
            mismatch_count++;
          end
          if (out_tlast !== want.is_final) begin
            $error("is_final: expected %0d, got %0d", want.is_final, out_tlast);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cmig_pkg::CFG_SHAPE_MODE)
          cur_shape <= cmig_pkg::shape_t'(cfg_data[cmig_pkg::MODE_W-1:0]);
        else if (cfg_index == cmig_pkg::CFG_NUM_SLICES)
          cur_slices <= cfg_data;
      end
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cylinder_mesh_index_generator verification failed");
      $finish;
    end
  end

  // drive one triangle number and hold it until accepted
  task automatic send_triangle(logic [cmig_pkg::TNUM_W-1:0] tnum);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cmig_pkg::IN_TDATA_W'(tnum);
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_register(cmig_pkg::cfg_reg_t idx,
                                logic [cmig_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mesh(cmig_pkg::shape_t shape, logic [cmig_pkg::CFG_DATA_W-1:0] slices);
    drain_results();
    write_register(cmig_pkg::CFG_SHAPE_MODE, cmig_pkg::CFG_DATA_W'(shape));
    write_register(cmig_pkg::CFG_NUM_SLICES, slices);
  endtask

  // reset configuration: capped cylinder, 16 slices, every region
  task automatic test_reset_defaults();
    send_triangle(12'd0);
    send_triangle(12'd15);    // top fan wrap
    send_triangle(12'd16);    // first side triangle
    send_triangle(12'd17);
    send_triangle(12'd46);
    send_triangle(12'd47);    // side wrap
    send_triangle(12'd48);    // bottom fan
    send_triangle(12'd63);    // last triangle
    send_triangle(12'd64);    // just past the mesh
    send_triangle(12'd4095);
  endtask

  task automatic test_cone();
    set_mesh(cmig_pkg::SHAPE_CONE, 11'd3);
    send_triangle(12'd0);
    send_triangle(12'd2);
    send_triangle(12'd3);
    send_triangle(12'd5);
    send_triangle(12'd6);
  endtask

  task automatic test_line_and_invalid();
    set_mesh(cmig_pkg::SHAPE_LINE, 11'd3);
    send_triangle(12'd0);
    send_triangle(12'd1);
    set_mesh(cmig_pkg::SHAPE_INVALID, 11'd3);
    send_triangle(12'd0);
  endtask

  task automatic test_slice_extremes();
    // zero slices: no cylinder, line still has its triangle
    set_mesh(cmig_pkg::SHAPE_CYL, 11'd0);
    send_triangle(12'd0);
    set_mesh(cmig_pkg::SHAPE_LINE, 11'd0);
    send_triangle(12'd0);
    // slice count above the limit is clamped
    set_mesh(cmig_pkg::SHAPE_CYL, 11'd2047);
    send_triangle(12'd4095);
    send_triangle(12'd3072);
    // single slice wraps onto itself
    set_mesh(cmig_pkg::SHAPE_CYL, 11'd1);
    send_triangle(12'd1);
    send_triangle(12'd3);
  endtask

  function automatic cmig_pkg::shape_t pick_shape();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return cmig_pkg::SHAPE_CONE;
    if (r < 80) return cmig_pkg::SHAPE_CYL;
    if (r < 92) return cmig_pkg::SHAPE_LINE;
    return cmig_pkg::SHAPE_INVALID;
  endfunction

  function automatic logic [cmig_pkg::CFG_DATA_W-1:0] pick_slices();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return cmig_pkg::CFG_DATA_W'($urandom_range(8, 1));
    if (r < 70) return cmig_pkg::CFG_DATA_W'($urandom_range(64, 9));
    if (r < 80) return cmig_pkg::CFG_DATA_W'(cmig_pkg::MAX_SLICES_DEF);
    if (r < 90)
      return cmig_pkg::CFG_DATA_W'($urandom_range(2047, cmig_pkg::MAX_SLICES_DEF + 1));
    if (r < 95) return '0;
    return cmig_pkg::CFG_DATA_W'($urandom);
  endfunction

  // triangle numbers mostly inside the mesh, with region borders and noise
  function automatic logic [cmig_pkg::TNUM_W-1:0] pick_triangle(
      cmig_pkg::shape_t shape, logic [cmig_pkg::CFG_DATA_W-1:0] slices);
    int unsigned total, n, r, v;
    total = mesh_size(shape, slices);
    n = clamp_slices(slices);
    r = $urandom_range(99);
    if (r < 60 && total > 0)
      v = $urandom_range(total - 1);
    else if (r < 80)
      case ($urandom_range(5))
        0: v = total - 1;
        1: v = total;
        2: v = n - 1;
        3: v = n;
        4: v = 3 * n - 1;
        default: v = 3 * n;
      endcase
    else
      v = $urandom;
    return v[cmig_pkg::TNUM_W-1:0];
  endfunction

  // random segments under each idling pattern
  task automatic test_random_meshes();
    int                              ph, seg, k;
    cmig_pkg::shape_t                shape;
    logic [cmig_pkg::CFG_DATA_W-1:0] slices;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (seg = 0; seg < SEGS_PER_PH; seg++) begin
        shape  = pick_shape();
        slices = pick_slices();
        set_mesh(shape, slices);
        for (k = 0; k < SEG_ITEMS; k++) begin
          // hold off once mid-segment until the pipe has emptied
          if (seg == 3 && k == SEG_ITEMS / 2)
            drain_results();
          send_triangle(pick_triangle(shape, slices));
        end
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_cone();
    test_line_and_invalid();
    test_slice_extremes();
    test_random_meshes();

    drain_results();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (pending_count() != 0) begin
      $error("%0d results never arrived", pending_count());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("cylinder_mesh_index_generator verification clean");
    end else begin
      $display("cylinder_mesh_index_generator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
